>>> sv/xmodem_checksum_receiver_assert.svh
// Assertion macros shared by the XMODEM checksum receiver RTL.
// Expects a clock named clock and a synchronous active-high reset named reset.
`ifndef XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH
`define XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define XMCR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define XMCR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/xmcr_pkg.sv
// Types, protocol bytes and helpers for the XMODEM checksum receiver.
// No dependencies; imported by xmcr_buf, xmodem_checksum_receiver and the bench.
`default_nettype none

package xmcr_pkg;

   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] INV_OK   = 8'hFF;

   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_TICK    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic CSR_PRG_BASE = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   localparam logic [1:0] STAT_BUSY     = 2'd0;
   localparam logic [1:0] STAT_OK       = 2'd1;
   localparam logic [1:0] STAT_BADSTART = 2'd2;
   localparam logic [1:0] STAT_TIMEOUT  = 2'd3;

   localparam int RSP_DATA_W = 112;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_HEADER,
      PH_NUM,
      PH_INV,
      PH_DATA,
      PH_OK,
      PH_BADSTART,
      PH_TIMEOUT
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EMIT
   } seq_type;

   // Result payload, send_valid in the lowest bit.
   typedef struct packed {
      logic [3:0]  pad;
      logic [1:0]  status;
      logic [63:0] write_data;
      logic [31:0] write_addr;
      logic        write_valid;
      logic [7:0]  send_byte;
      logic        send_valid;
   } rsp_data_type;

   function automatic logic [1:0] status_of(input phase_type ph);
      logic [1:0] st;
      case (ph)
         PH_OK:       st = STAT_OK;
         PH_BADSTART: st = STAT_BADSTART;
         PH_TIMEOUT:  st = STAT_TIMEOUT;
         default:     st = STAT_BUSY;
      endcase
      return st;
   endfunction

endpackage

`default_nettype wire

>>> sv/xmcr_buf.sv
// Packet data buffer: one 64-bit word per entry, byte-lane writes, registered read.
// Depends on xmcr_pkg.
`default_nettype none

module xmcr_buf #(
   parameter int WORDS  = 16,
   parameter int WORD_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [WORD_W-1:0] wr_word,
   input  wire logic [2:0]        wr_lane,
   input  wire logic [7:0]        wr_byte,
   input  wire logic              rd_en,
   input  wire logic [WORD_W-1:0] rd_word,
   output logic      [63:0]       rd_data
);
   import xmcr_pkg::*;

   logic [63:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_word][{wr_lane, 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_word];
      end
   end

endmodule

`default_nettype wire

>>> sv/xmodem_checksum_receiver.sv
// Top level of the XMODEM checksum receiver: protocol state, buffer and result queue.
// Depends on xmcr_pkg, xmcr_buf and xmodem_checksum_receiver_assert.svh.
//
// Usage:
//   req_* carries one item per handshake: tuser = mode (restart, retry tick,
//   received byte), tdata = the received byte. rsp_* returns result items:
//   reply byte to send, a 64-bit memory word write, transfer status, and
//   tlast on the final result of each input item. csr_* writes prg_base
//   (index 0) and timeout_ticks (index 1) with no wait; write only while idle.
// Throughput:
//   An ordinary item gives its single result in the output register in the cycle
//   after acceptance and the next item can be taken in that same cycle, so one
//   item per cycle while the receiver keeps up. A good checksum byte unloads the
//   packet buffer one word per cycle while the receiver keeps up: DATA_BYTES/8
//   (rounded up) results, read in SEQ_READ and then emitted from SEQ_EMIT; the single
//   read port of the buffer memory sets that rate, and no item is taken during the unload.
// Reset:
//   Synchronous. Registers return to prg_base 0, timeout_ticks 10000 and the
//   wait for the first byte. The buffer is not cleared: each packet rewrites
//   every byte before the buffer is read.
// Stalls:
//   When rsp_tready is low the result holds in the output register and
//   req_tready drops until it is taken; nothing is lost or repeated.
`default_nettype none
`include "xmodem_checksum_receiver_assert.svh"

module xmodem_checksum_receiver #(
   parameter int DATA_BYTES = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // input item
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]   req_tuser,   // [1:0] mode
   // result item
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [111:0]      rsp_tdata,   // [0] send_valid, [8:1] send_byte,
                                          // [9] write_valid, [41:10] write_addr,
                                          // [105:42] write_data, [107:106] status
   output logic              rsp_tlast,
   // register writes
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [31:0]  csr_wdata
);
   import xmcr_pkg::*;

   localparam int WORDS  = (DATA_BYTES + 7) / 8;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W  = $clog2(DATA_BYTES + 1);
   localparam int TAIL   = DATA_BYTES % 8;
   localparam logic [63:0] TAIL_MASK =
      (TAIL == 0) ? {64{1'b1}} : ((64'd1 << (8 * TAIL)) - 64'd1);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);

   // Configuration registers
   logic [31:0] prg_base_ff;
   logic [23:0] timeout_ff;

   // Protocol state
   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       num_ff, num_in;
   logic [7:0]       inv_ff, inv_in;
   logic [7:0]       sum_ff, sum_in;
   logic [23:0]      tick_ff, tick_in;

   // Unload sequencer
   seq_type          seq_ff, seq_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [31:0]      waddr_ff, waddr_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             rsp_free;
   logic             good_pkt;
   logic [7:0]       reply;
   logic [23:0]      tick_next;
   logic [31:0]      blk_m1;

   logic             buf_wr_en;
   logic             buf_rd_en;
   logic [WORD_W-1:0] buf_rd_word;
   logic [63:0]      buf_rd_data;
   logic             load_single;
   logic             load_word;
   logic             last_word;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == SEQ_IDLE) && rsp_free;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign last_word  = (word_ff == LAST_WORD);

   // Block number minus one, as a 32-bit two's complement offset factor.
   assign blk_m1 = {{24{num_ff == 8'd0}}, num_ff - 8'd1};

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_base_ff <= 32'd0;
         timeout_ff  <= 24'd10000;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PRG_BASE: prg_base_ff <= csr_wdata;
            CSR_TIMEOUT:  timeout_ff  <= csr_wdata[23:0];
            default:      ;
         endcase
      end
   end

   // Protocol: advance the phase on each accepted item.
   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      num_in    = num_ff;
      inv_in    = inv_ff;
      sum_in    = sum_ff;
      tick_in   = tick_ff;
      tick_next = tick_ff + 24'd1;
      reply     = 8'h00;
      good_pkt  = 1'b0;
      buf_wr_en = 1'b0;
      if (req_accept) begin
         case (req_tuser)
            MODE_RESTART: begin
               phase_in = PH_WAIT;
               tick_in  = 24'd0;
               idx_in   = '0;
               num_in   = 8'd0;
               inv_in   = 8'd0;
               sum_in   = 8'd0;
               if (timeout_ff == 24'd0) begin
                  phase_in = PH_TIMEOUT;
               end else begin
                  reply = BYTE_NAK;
               end
            end
            MODE_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  tick_in = tick_next;
                  if (tick_next >= timeout_ff) begin
                     phase_in = PH_TIMEOUT;
                  end else begin
                     reply = BYTE_NAK;
                  end
               end
            end
            MODE_BYTE: begin
               case (phase_ff)
                  PH_WAIT: begin
                     phase_in = (req_tdata == BYTE_SOH) ? PH_NUM : PH_BADSTART;
                  end
                  PH_HEADER: begin
                     if (req_tdata == BYTE_EOT) begin
                        phase_in = PH_OK;
                        reply    = BYTE_ACK;
                     end else if (req_tdata == BYTE_SOH) begin
                        phase_in = PH_NUM;
                     end else begin
                        phase_in = PH_BADSTART;
                     end
                  end
                  PH_NUM: begin
                     num_in   = req_tdata;
                     phase_in = PH_INV;
                  end
                  PH_INV: begin
                     inv_in   = req_tdata;
                     idx_in   = '0;
                     sum_in   = 8'd0;
                     phase_in = PH_DATA;
                  end
                  PH_DATA: begin
                     if (idx_ff < IDX_W'(DATA_BYTES)) begin
                        buf_wr_en = 1'b1;
                        sum_in    = sum_ff + req_tdata;
                        idx_in    = idx_ff + IDX_W'(1);
                     end else begin
                        // checksum byte
                        phase_in = PH_HEADER;
                        idx_in   = '0;
                        if (((num_ff ^ inv_ff) != INV_OK) || (sum_ff != req_tdata)) begin
                           reply = BYTE_NAK;
                        end else begin
                           good_pkt = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         idx_ff   <= '0;
         num_ff   <= 8'd0;
         inv_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         tick_ff  <= 24'd0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         num_ff   <= num_in;
         inv_ff   <= inv_in;
         sum_ff   <= sum_in;
         tick_ff  <= tick_in;
      end
   end

   xmcr_buf #(
      .WORDS  (WORDS),
      .WORD_W (WORD_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_word (idx_ff[WORD_W+2:3]),
      .wr_lane (idx_ff[2:0]),
      .wr_byte (req_tdata),
      .rd_en   (buf_rd_en),
      .rd_word (buf_rd_word),
      .rd_data (buf_rd_data)
   );

   // Unload sequencer: next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (good_pkt) begin
               seq_in = SEQ_READ;
            end
         end
         SEQ_READ: seq_in = SEQ_EMIT;
         SEQ_EMIT: begin
            if (rsp_free && last_word) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // Unload sequencer: outputs. Read word 0, then prefetch the next word as
   // each one moves into the output register.
   always_comb begin
      buf_rd_en   = 1'b0;
      buf_rd_word = word_ff;
      load_word   = 1'b0;
      word_in     = word_ff;
      waddr_in    = waddr_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            word_in = '0;
            if (good_pkt) begin
               waddr_in = prg_base_ff + blk_m1 * 32'(DATA_BYTES);
            end
         end
         SEQ_READ: begin
            buf_rd_en = 1'b1;
         end
         SEQ_EMIT: begin
            if (rsp_free) begin
               load_word = 1'b1;
               if (!last_word) begin
                  word_in     = word_ff + WORD_W'(1);
                  buf_rd_word = word_in;
                  buf_rd_en   = 1'b1;
                  waddr_in    = waddr_ff + 32'd8;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= SEQ_IDLE;
         word_ff <= '0;
      end else begin
         seq_ff  <= seq_in;
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff <= waddr_in;
   end

   // Output register: single results load on acceptance, words load from the
   // buffer; hold while the receiver stalls.
   assign load_single = req_accept && !good_pkt;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_single) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in.send_valid  = (reply != 8'h00);
         rsp_data_in.send_byte   = reply;
         rsp_data_in.status      = status_of(phase_in);
         rsp_last_in             = 1'b1;
      end else if (load_word) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in.send_valid  = last_word;
         rsp_data_in.send_byte   = last_word ? BYTE_ACK : 8'h00;
         rsp_data_in.write_valid = 1'b1;
         rsp_data_in.write_addr  = waddr_ff;
         rsp_data_in.write_data  = last_word ? (buf_rd_data & TAIL_MASK) : buf_rd_data;
         rsp_data_in.status      = status_of(phase_ff);
         rsp_last_in             = last_word;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `XMCR_ASSERT_NOW(a_no_write_in_unload, buf_wr_en, seq_ff == SEQ_IDLE, "buffer write during unload")
   `XMCR_ASSERT_NOW(a_word_in_range, seq_ff != SEQ_IDLE, word_ff <= LAST_WORD, "word counter past end")
   `XMCR_ASSERT_NEXT(a_good_starts_unload, req_accept && good_pkt, (seq_ff == SEQ_READ) && (word_ff == '0), "good packet did not start unload")
   `XMCR_ASSERT_NEXT(a_ack_on_last_word, load_word && last_word, rsp_tlast && (rsp_data_ff.send_byte == BYTE_ACK), "last word lacks ACK")

endmodule

`default_nettype wire

>>> bench/xmodem_checksum_receiver_test.sv
// Self-checking bench for xmodem_checksum_receiver: directed transfers, then random ones.
// Depends on xmcr_pkg and the receiver RTL; a built-in predictor supplies expected replies.
module xmodem_checksum_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import xmcr_pkg::*;

   localparam int DATA_BYTES = 128;
   localparam int WORDS = (DATA_BYTES + 7) / 8;
   // The fourth mode code has no meaning; the receiver must ignore it.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CAP = 5000;
   localparam int RANDOM_ITEMS = 60;

   // One expected reply of the receiver, in the order the fields travel.
   typedef struct packed {
      logic        send_valid;
      logic [7:0]  send_byte;
      logic        write_valid;
      logic [31:0] write_addr;
      logic [63:0] write_data;
      logic [1:0]  status;
      logic        last;
   } reply_item;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] rx_byte
   logic [1:0]   req_tuser;   // [1:0] mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;   // [0] send_valid, [8:1] send_byte, [9] write_valid,
                              // [41:10] write_addr, [105:42] write_data, [107:106] status
   logic         rsp_tlast;
   logic         csr_we;
   logic         csr_addr;
   logic [31:0]  csr_wdata;

   xmodem_checksum_receiver #(
      .DATA_BYTES(DATA_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mirror of the receiver: registers and protocol state.
   logic [31:0] cfg_base;
   logic [23:0] cfg_timeout;
   phase_type   rx_phase;
   int          byte_count;
   logic [7:0]  blk_num;
   logic [7:0]  blk_inv;
   logic [7:0]  data_sum;
   logic [23:0] tick_count;
   logic [7:0]  packet_bytes [DATA_BYTES];

   reply_item pending_replies[$];

   int  error_count = 0;
   int  items_sent = 0;
   int  replies_checked = 0;
   int  packets_written = 0;
   int  packets_rejected = 0;
   int  transfers_run = 0;
   int  random_items = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      // Keep the log short on a systematic fault; keep counting anyway.
      if (error_count < 50)
         $display("mismatch %s at reply %0d: got %h want %h", what, replies_checked, got, want);
      error_count++;
   endtask

   function automatic int draw_gap(input bit enabled);
      return enabled ? $urandom_range(0, 10) : 0;
   endfunction

   // Queue one reply; the status reflects the phase after this input.
   function automatic void push_reply(input logic [7:0] sbyte, input logic wv,
                                      input logic [31:0] wa, input logic [63:0] wd,
                                      input logic last);
      reply_item r;
      r.send_valid  = (sbyte != 8'h00);
      r.send_byte   = sbyte;
      r.write_valid = wv;
      r.write_addr  = wv ? wa : 32'h0;
      r.write_data  = wv ? wd : 64'h0;
      case (rx_phase)
         PH_OK:       r.status = STAT_OK;
         PH_BADSTART: r.status = STAT_BADSTART;
         PH_TIMEOUT:  r.status = STAT_TIMEOUT;
         default:     r.status = STAT_BUSY;
      endcase
      r.last = last;
      pending_replies.push_back(r);
   endfunction

   // Advance the mirrored receiver by one accepted item and queue its replies.
   function automatic void predict_replies(input logic [1:0] mode, input logic [7:0] b);
      logic [7:0]  reply;
      logic [31:0] addr;
      logic [63:0] word;
      reply = 8'h00;
      case (mode)
         MODE_RESTART: begin
            rx_phase   = PH_WAIT;
            tick_count = 24'h0;
            byte_count = 0;
            blk_num    = 8'h00;
            blk_inv    = 8'h00;
            data_sum   = 8'h00;
            if (cfg_timeout == 24'h0) rx_phase = PH_TIMEOUT;
            else reply = BYTE_NAK;
         end
         MODE_TICK: begin
            // Ticks count only while waiting for the first byte.
            if (rx_phase == PH_WAIT) begin
               tick_count = tick_count + 24'h1;
               if (tick_count >= cfg_timeout) rx_phase = PH_TIMEOUT;
               else reply = BYTE_NAK;
            end
         end
         MODE_BYTE: begin
            case (rx_phase)
               PH_WAIT: rx_phase = (b == BYTE_SOH) ? PH_NUM : PH_BADSTART;
               PH_HEADER: begin
                  if (b == BYTE_EOT) begin
                     rx_phase = PH_OK;
                     reply = BYTE_ACK;
                  end else if (b == BYTE_SOH) begin
                     rx_phase = PH_NUM;
                  end else begin
                     rx_phase = PH_BADSTART;
                  end
               end
               PH_NUM: begin
                  blk_num  = b;
                  rx_phase = PH_INV;
               end
               PH_INV: begin
                  blk_inv    = b;
                  byte_count = 0;
                  data_sum   = 8'h00;
                  rx_phase   = PH_DATA;
               end
               PH_DATA: begin
                  if (byte_count < DATA_BYTES) begin
                     packet_bytes[byte_count] = b;
                     data_sum = data_sum + b;
                     byte_count++;
                  end else begin
                     // Checksum byte: reject, or unload the buffer word by word.
                     rx_phase   = PH_HEADER;
                     byte_count = 0;
                     if ((blk_num ^ blk_inv) != INV_OK || data_sum != b) begin
                        reply = BYTE_NAK;
                        packets_rejected++;
                     end else begin
                        addr = cfg_base + (32'(blk_num) - 32'd1) * 32'(DATA_BYTES);
                        for (int w = 0; w < WORDS; w++) begin
                           word = 64'h0;
                           for (int i = 0; i < 8; i++)
                              if (w * 8 + i < DATA_BYTES)
                                 word[8 * i +: 8] = packet_bytes[w * 8 + i];
                           push_reply((w == WORDS - 1) ? BYTE_ACK : 8'h00, 1'b1,
                                      addr + 32'(w) * 32'd8, word, w == WORDS - 1);
                        end
                        packets_written++;
                        return;
                     end
                  end
               end
               default: ;  // finished: hold the status until a restart
            endcase
         end
         default: ;  // unused mode: one reply with the current status
      endcase
      push_reply(reply, 1'b0, 32'h0, 64'h0, 1'b1);
   endfunction

   // Drive one item, after a random gap if send_idle is set, and hold it until the receiver takes it.
   task automatic send_item(input logic [1:0] mode, input logic [7:0] rx_byte);
      int gap;
      gap = draw_gap(send_idle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= rx_byte;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_replies(mode, rx_byte);
   endtask

   // Drop valid and hold off until every expected reply has arrived or the DRAIN_CAP wait runs out; report any missing.
   task automatic wait_drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_replies.size() != 0 && waited < DRAIN_CAP);
      if (pending_replies.size() != 0) begin
         report_mismatch("replies missing", 64'(pending_replies.size()), 64'h0);
         pending_replies.delete();
      end
   endtask

   // Write one register; the receiver must be idle when this is called.
   task automatic write_register(input logic index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_PRG_BASE) cfg_base = value;
      else cfg_timeout = value[23:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Send SOH, number, complement, the data bytes and the checksum.
   // pattern: 0 random data, 1 all zeros, 2 all ones. noisy mixes in ignored items.
   task automatic send_packet(input logic [7:0] num, input bit bad_inv, input bit bad_sum,
                              input int pattern, input bit noisy);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      sum = 8'h00;
      send_item(MODE_BYTE, BYTE_SOH);
      send_item(MODE_BYTE, num);
      send_item(MODE_BYTE, bad_inv ? (~num ^ (8'h01 << $urandom_range(0, 7))) : ~num);
      for (i = 0; i < DATA_BYTES; i++) begin
         if (noisy && $urandom_range(0, 39) == 0)
            send_item($urandom_range(0, 1) ? MODE_TICK : MODE_UNUSED, 8'($urandom));
         case (pattern)
            0:       b = 8'($urandom);
            1:       b = 8'h00;
            default: b = 8'hFF;
         endcase
         sum = sum + b;
         send_item(MODE_BYTE, b);
      end
      send_item(MODE_BYTE, bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
   endtask

   // Zero timeout, tick limit, ignored ticks and the unused mode.
   task automatic test_timeouts();
      wait_drain();
      write_register(CSR_TIMEOUT, 32'd0);
      send_item(MODE_RESTART, 8'h00);     // ends at once, no NAK
      send_item(MODE_TICK, 8'hFF);
      send_item(MODE_BYTE, BYTE_SOH);     // finished: ignored
      wait_drain();
      write_register(CSR_TIMEOUT, 32'd3);
      send_item(MODE_RESTART, 8'hFF);
      send_item(MODE_UNUSED, 8'hA5);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_TICK, 8'h5A);
      send_item(MODE_TICK, 8'h00);        // reaches the limit, no NAK
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, 8'h80);
      transfers_run += 2;
   endtask

   // First byte other than SOH ends the transfer with an error.
   task automatic test_bad_start();
      wait_drain();
      write_register(CSR_TIMEOUT, 32'h00FF_FFFF);
      send_item(MODE_RESTART, 8'h00);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, 8'hFF);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, BYTE_SOH);
      send_item(MODE_UNUSED, 8'h00);
      transfers_run++;
   endtask

   // Rejected first packet, block zero wrap past the top base address, then EOT.
   task automatic test_packets();
      wait_drain();
      write_register(CSR_PRG_BASE, 32'hFFFF_FFFF);
      write_register(CSR_TIMEOUT, 32'd16);
      send_item(MODE_RESTART, 8'hFF);
      send_item(MODE_TICK, 8'h00);
      send_packet(8'h01, 1'b1, 1'b0, 1, 1'b0);  // bad complement on the first packet
      wait_drain();                              // pause mid-transfer
      send_packet(8'h00, 1'b0, 1'b0, 0, 1'b1);  // SOH still taken; block zero wraps
      send_item(MODE_BYTE, BYTE_EOT);
      send_item(MODE_BYTE, BYTE_SOH);
      send_item(MODE_TICK, 8'h00);
      transfers_run++;
   endtask

   // A few ignored or disruptive items after a transfer has ended.
   task automatic send_noise();
      int n;
      n = $urandom_range(0, 2);
      repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   // One random transfer: mostly a well-formed packet with random content.
   task automatic run_random_transfer();
      int         pick;
      int         n;
      logic [7:0] num;
      logic [7:0] b;
      int         start_count;
      start_count = items_sent;
      wait_drain();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) write_register(CSR_TIMEOUT, 32'($urandom_range(0, 2)));
      else if (pick == 1) write_register(CSR_TIMEOUT, 32'h00FF_FFFF);
      else if (pick < 5) write_register(CSR_TIMEOUT, 32'($urandom_range(1, 8)));
      pick = $urandom_range(0, 5);
      if (pick == 0) write_register(CSR_PRG_BASE, 32'h0);
      else if (pick == 1) write_register(CSR_PRG_BASE, 32'hFFFF_FFFF);
      else if (pick < 4) write_register(CSR_PRG_BASE, $urandom);
      send_item(MODE_RESTART, 8'($urandom));
      n = $urandom_range(0, 4);
      repeat (n) send_item(MODE_TICK, 8'($urandom));
      transfers_run++;
      if (rx_phase != PH_WAIT) begin
         // Timed out: everything after is ignored until the next restart.
         send_noise();
      end else if ($urandom_range(0, 9) == 0) begin
         do b = 8'($urandom); while (b == BYTE_SOH);
         send_item(MODE_BYTE, b);
         send_noise();
      end else begin
         num = 8'($urandom);
         pick = $urandom_range(0, 9);
         send_packet(num, pick == 0, pick == 1, ($urandom_range(0, 7) == 0) ? 2 : 0,
                     $urandom_range(0, 2) == 0);
         if ($urandom_range(0, 7) == 0) wait_drain();
         pick = $urandom_range(0, 5);
         if (pick < 4) begin
            send_item(MODE_BYTE, BYTE_EOT);
         end else if (pick == 4) begin
            do b = 8'($urandom); while (b == BYTE_SOH || b == BYTE_EOT);
            send_item(MODE_BYTE, b);
         end
         send_noise();
      end
      random_items += items_sent - start_count;
   endtask

   task automatic test_random_transfers();
      while (random_items < RANDOM_ITEMS) run_random_transfer();
   endtask

   // Compare one accepted reply, field by field, with the oldest expectation.
   task automatic check_reply(input logic [111:0] data, input logic tlast);
      rsp_data_type got;
      reply_item    want;
      got = rsp_data_type'(data);
      if (pending_replies.size() == 0) begin
         report_mismatch("unexpected reply", data[63:0], 64'h0);
         return;
      end
      want = pending_replies.pop_front();
      if (got.send_valid !== want.send_valid)
         report_mismatch("send_valid", 64'(got.send_valid), 64'(want.send_valid));
      if (got.send_byte !== want.send_byte)
         report_mismatch("send_byte", 64'(got.send_byte), 64'(want.send_byte));
      if (got.write_valid !== want.write_valid)
         report_mismatch("write_valid", 64'(got.write_valid), 64'(want.write_valid));
      if (got.write_addr !== want.write_addr)
         report_mismatch("write_addr", 64'(got.write_addr), 64'(want.write_addr));
      if (got.write_data !== want.write_data)
         report_mismatch("write_data", got.write_data, want.write_data);
      if (got.status !== want.status)
         report_mismatch("status", 64'(got.status), 64'(want.status));
      if (tlast !== want.last)
         report_mismatch("tlast", 64'(tlast), 64'(want.last));
      replies_checked++;
   endtask

   // Receiving side: stall for a random gap before each reply while recv_idle is set, then check it.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap(recv_idle);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_reply(rsp_tdata, rsp_tlast);
      end
   end

   // Main sequence: reset once, then each test in turn.
   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= MODE_BYTE;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_PRG_BASE;
      csr_wdata  <= 32'h0;
      // Reset values of the mirror.
      cfg_base    = 32'h0;
      cfg_timeout = 24'd10000;
      rx_phase    = PH_WAIT;
      byte_count  = 0;
      blk_num     = 8'h00;
      blk_inv     = 8'h00;
      data_sum    = 8'h00;
      tick_count  = 24'h0;
      for (int i = 0; i < DATA_BYTES; i++) packet_bytes[i] = 8'h00;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_timeouts();
      test_bad_start();
      test_packets();
      test_random_transfers();

      wait_drain();
      repeat (WORDS + 4) @(posedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("replies left over", 64'(pending_replies.size()), 64'h0);

      $display("covered %0d transfers, %0d items, %0d replies checked",
               transfers_run, items_sent, replies_checked);
      $display("packets written %0d, packets rejected %0d, mismatches %0d",
               packets_written, packets_rejected, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: end a hung run well past the slowest legal one.
   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
